/* design/lut3d_tetrahedral_color_map_assert.svh */
// Assertion macros shared by the color map RTL.
`ifndef LUT3D_TETRAHEDRAL_COLOR_MAP_ASSERT_SVH
`define LUT3D_TETRAHEDRAL_COLOR_MAP_ASSERT_SVH
`ifndef ASSERT_OFF
// Check that a property holds at every clock out of reset.
`define LCM_ASSERT(label, ck, rn, prop) \
    label: assert property (@(posedge ck) disable iff (!rn) (prop)) \
        else $error("lut3d: property violated");
// Check that a condition never occurs out of reset.
`define LCM_NEVER(label, ck, rn, cond) \
    label: assert property (@(posedge ck) disable iff (!rn) !(cond)) \
        else $error("lut3d: forbidden condition");
`else
`define LCM_ASSERT(label, ck, rn, prop)
`define LCM_NEVER(label, ck, rn, cond)
`endif
`endif

/* design/lut3d_pkg.sv */
// Shared constants and types of the 3D LUT color map.
package lut3d_pkg;

    // Default sizing
    localparam int MAX_LATTICE_DEF  = 33;
    localparam int SHAPER_DEPTH_DEF = 1024;
    localparam int SAMPLE_BITS_DEF  = 20;
    localparam int QUEUE_DEPTH      = 4;

    // Weight width: one in Q.16 needs 17 bits
    localparam int WGT_BITS = 17;

    // Command codes
    localparam logic [1:0] CMD_PIXEL  = 2'd0;
    localparam logic [1:0] CMD_LWRITE = 2'd1;
    localparam logic [1:0] CMD_SWRITE = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] CFG_LATTICE_SIZE = 3'd0;
    localparam logic [2:0] CFG_SHAPER_SIZE  = 3'd1;
    localparam logic [2:0] CFG_SCALE_RED    = 3'd2;
    localparam logic [2:0] CFG_SCALE_GREEN  = 3'd3;
    localparam logic [2:0] CFG_SCALE_BLUE   = 3'd4;
    localparam logic [2:0] CFG_MAP_RED      = 3'd5;
    localparam logic [2:0] CFG_MAP_GREEN    = 3'd6;
    localparam logic [2:0] CFG_MAP_BLUE     = 3'd7;

    // Reset values
    localparam logic [5:0]  LATTICE_SIZE_RST = 6'd33;
    localparam logic [23:0] SCALE_RST        = 24'd65536;

    // Kind of work handed from front to back
    typedef enum logic {
        KIND_PIXEL,
        KIND_LWRITE
    } kind_t;

endpackage

/* design/lut3d_queue.sv */
// Small FIFO between the front and back ends.
`include "lut3d_tetrahedral_color_map_assert.svh"
module lut3d_queue #(
    parameter int W     = 8,
    parameter int DEPTH = lut3d_pkg::QUEUE_DEPTH
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push_valid,
    output logic         push_ready,
    input  logic [W-1:0] push_data,
    output logic         pop_valid,
    input  logic         pop_ready,
    output logic [W-1:0] pop_data
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  slot_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] cnt_reg;
    logic          push, pop;

    assign push_ready = cnt_reg != CW'(DEPTH);
    assign pop_valid  = cnt_reg != '0;
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    // Store a pushed entry
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    `LCM_NEVER(a_q_count_range, clk, rst_n, cnt_reg > CW'(DEPTH))
    `LCM_ASSERT(a_q_push_count, clk, rst_n, (push && !pop) |=> (cnt_reg == $past(cnt_reg) + 1'b1))

endmodule

/* design/lut3d_front.sv */
// Front end: accept items, run shaper and lattice position math, classify.
module lut3d_front #(
    parameter int MAX_LATTICE  = lut3d_pkg::MAX_LATTICE_DEF,
    parameter int SHAPER_DEPTH = lut3d_pkg::SHAPER_DEPTH_DEF,
    parameter int SAMPLE_BITS  = lut3d_pkg::SAMPLE_BITS_DEF,
    parameter int QW           = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [1:0]                    command,
    input  logic signed [SAMPLE_BITS-1:0] red,
    input  logic signed [SAMPLE_BITS-1:0] green,
    input  logic signed [SAMPLE_BITS-1:0] blue,
    input  logic signed [SAMPLE_BITS-1:0] alpha,
    input  logic [15:0]                   entry_index,
    input  logic [1:0]                    shaper_channel,
    input  logic [5:0]                    lattice_size,
    input  logic [10:0]                   shaper_size,
    input  logic [2:0][23:0]              scale,
    input  logic [2:0][55:0]              shaper_map,
    output logic                          q_valid,
    input  logic                          q_ready,
    output logic [QW-1:0]                 q_data
);
    localparam int S         = SAMPLE_BITS;
    localparam int LAT_DEPTH = MAX_LATTICE * MAX_LATTICE * MAX_LATTICE;
    localparam int LAT_AW    = $clog2(LAT_DEPTH);
    localparam int LS_W      = $clog2(MAX_LATTICE + 1);
    localparam int SH_AW     = $clog2(SHAPER_DEPTH);
    localparam int SH_SW     = $clog2(SHAPER_DEPTH + 1);
    localparam int DW        = ((S > 24) ? S : 24) + 1;
    localparam int XW        = DW + 15;
    localparam int CW        = (XW > SH_SW + 16) ? XW : SH_SW + 16;
    localparam int LW        = S + 18;
    localparam int T1W       = S + 25;
    localparam int TW        = T1W + LS_W + 1;
    localparam int PW        = TW - 16;
    localparam int WB        = lut3d_pkg::WGT_BITS;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [2:0][S-1:0] smp;
        logic [S-1:0]      alpha;
        logic [15:0]       idx;
        logic [1:0]        ch;
    } car_t;

    logic [7:1]  vld_reg;
    car_t        car_reg [1:7];
    car_t        car_in;
    logic        f_adv;
    logic        push_need;

    // Configuration derived values
    logic [31:0]      ls_ext, sh_ext;
    logic [LS_W-1:0]  size, lmax;
    logic [SH_SW-1:0] shsz, sh_last;
    logic             shaper_on;

    assign ls_ext    = 32'(lattice_size);
    assign sh_ext    = 32'(shaper_size);
    assign size      = (ls_ext < 32'd2) ? LS_W'(2) :
                       ((ls_ext > 32'(MAX_LATTICE)) ? LS_W'(MAX_LATTICE) : LS_W'(ls_ext));
    assign lmax      = size - 1'b1;
    assign shsz      = (sh_ext > 32'(SHAPER_DEPTH)) ? SH_SW'(SHAPER_DEPTH) : SH_SW'(sh_ext);
    assign sh_last   = shsz - 1'b1;
    assign shaper_on = shsz != '0;

    // Pack the accepted item
    always_comb
    begin
        car_in.cmd    = command;
        car_in.smp[0] = red;
        car_in.smp[1] = green;
        car_in.smp[2] = blue;
        car_in.alpha  = alpha;
        car_in.idx    = entry_index;
        car_in.ch     = shaper_channel;
    end

    // Stage valids and carried payload
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (f_adv)
        begin
            vld_reg <= {vld_reg[6:1], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (f_adv)
        begin
            car_reg[1] <= car_in;
            for (int k = 2; k <= 7; k++)
            begin
                car_reg[k] <= car_reg[k-1];
            end
        end
    end

    assign in_ready = f_adv;

    // Stage 1: shaper input position, (v - offset) * scale
    logic signed [DW-1:0] s1_diff [3];
    logic [DW-2:0]        s1_ud   [3];
    logic [DW+30:0]       s1_prod [3];
    logic [XW-1:0]        s2_x_reg [3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            s1_diff[k] = DW'($signed(car_reg[1].smp[k]))
                       - DW'($signed(shaper_map[k][55:32]));
            s1_ud[k]   = (s1_diff[k] <= 0) ? '0 : s1_diff[k][DW-2:0];
            s1_prod[k] = (DW + 31)'(s1_ud[k]) * (DW + 31)'(shaper_map[k][31:0]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (f_adv)
        begin
            for (int k = 0; k < 3; k++)
            begin
                s2_x_reg[k] <= s1_prod[k][DW+30:16];
            end
        end
    end

    // Stage 2: clamp to the table, form neighbor addresses, read shaper
    logic [CW-1:0]    s2_top;
    logic [CW-1:0]    s2_xc   [3];
    logic [SH_AW-1:0] s2_prev [3];
    logic [SH_AW-1:0] s2_next [3];
    logic [SH_SW-1:0] s2_nx   [3];
    logic [15:0]      s3_d_reg [3];
    logic             sh_wr;
    logic [SH_AW-1:0] sh_waddr;
    logic signed [S-1:0] shp_p [3];
    logic signed [S-1:0] shp_n [3];

    assign s2_top = CW'({sh_last, 16'h0});

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            s2_xc[k]   = (CW'(s2_x_reg[k]) > s2_top) ? s2_top : CW'(s2_x_reg[k]);
            s2_prev[k] = s2_xc[k][SH_AW+15:16];
            s2_nx[k]   = SH_SW'(s2_prev[k]) + 1'b1;
            s2_next[k] = (s2_nx[k] > sh_last) ? sh_last[SH_AW-1:0] : s2_nx[k][SH_AW-1:0];
        end
    end

    assign sh_wr    = f_adv && vld_reg[2] && car_reg[2].cmd == lut3d_pkg::CMD_SWRITE
                      && 32'(car_reg[2].idx) < 32'(SHAPER_DEPTH);
    assign sh_waddr = SH_AW'(32'(car_reg[2].idx));

    for (genvar g = 0; g < 3; g++)
    begin : g_shaper
        logic [S-1:0] mem [SHAPER_DEPTH];
        logic [S-1:0] p_rd_reg, n_rd_reg;

        // Write entries in stream order, read both neighbors
        always_ff @(posedge clk)
        begin
            if (sh_wr && car_reg[2].ch == 2'(g))
            begin
                mem[sh_waddr] <= car_reg[2].smp[0];
            end
            if (f_adv)
            begin
                p_rd_reg <= mem[s2_prev[g]];
                n_rd_reg <= mem[s2_next[g]];
            end
        end

        assign shp_p[g] = $signed(p_rd_reg);
        assign shp_n[g] = $signed(n_rd_reg);
    end

    always_ff @(posedge clk)
    begin
        if (f_adv)
        begin
            for (int k = 0; k < 3; k++)
            begin
                s3_d_reg[k] <= s2_xc[k][15:0];
            end
        end
    end

    // Stage 3: lerp product (n - p) * d
    logic signed [S:0]    s3_dl [3];
    logic signed [LW-1:0] s4_lerp_reg [3];
    logic signed [S-1:0]  s4_p_reg    [3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            s3_dl[k] = (S + 1)'(shp_n[k]) - (S + 1)'(shp_p[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (f_adv)
        begin
            for (int k = 0; k < 3; k++)
            begin
                s4_lerp_reg[k] <= LW'(s3_dl[k]) * LW'($signed({1'b0, s3_d_reg[k]}));
                s4_p_reg[k]    <= shp_p[k];
            end
        end
    end

    // Stage 4: round lerp, pick shaped or raw sample, multiply by scale
    logic signed [LW-1:0]  s4_rnd [3];
    logic signed [LW-1:0]  s4_vw  [3];
    logic signed [S-1:0]   s4_v   [3];
    logic signed [T1W-1:0] s5_t1_reg [3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            s4_rnd[k] = (s4_lerp_reg[k] + LW'(32768)) >>> 16;
            s4_vw[k]  = LW'(s4_p_reg[k]) + s4_rnd[k];
            s4_v[k]   = shaper_on ? s4_vw[k][S-1:0] : $signed(car_reg[4].smp[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (f_adv)
        begin
            for (int k = 0; k < 3; k++)
            begin
                s5_t1_reg[k] <= T1W'(s4_v[k]) * T1W'($signed({1'b0, scale[k]}));
            end
        end
    end

    // Stage 5: times (size - 1), clamp, split into floor and fraction
    logic signed [TW-1:0] s5_t   [3];
    logic [PW-1:0]        s5_pos [3];
    logic [PW-1:0]        s5_lim;
    logic [LS_W:0]        s5_nx  [3];
    logic [LS_W-1:0]      s6_prev_reg [3];
    logic [LS_W-1:0]      s6_next_reg [3];
    logic [15:0]          s6_fr_reg   [3];
    logic [LS_W-1:0]      s5_prev [3];

    assign s5_lim = PW'({lmax, 16'h0});

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            s5_t[k] = TW'(s5_t1_reg[k]) * TW'($signed({1'b0, lmax}));
            if (s5_t[k] <= 0)
            begin
                s5_pos[k] = '0;
            end
            else
            begin
                s5_pos[k] = s5_t[k][TW-1:16];
            end
            if (s5_pos[k] > s5_lim)
            begin
                s5_pos[k] = s5_lim;
            end
            s5_prev[k] = s5_pos[k][LS_W+15:16];
            s5_nx[k]   = (LS_W + 1)'(s5_prev[k]) + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (f_adv)
        begin
            for (int k = 0; k < 3; k++)
            begin
                s6_prev_reg[k] <= s5_prev[k];
                s6_fr_reg[k]   <= s5_pos[k][15:0];
                s6_next_reg[k] <= (s5_nx[k] > (LS_W + 1)'(lmax)) ? lmax : s5_nx[k][LS_W-1:0];
            end
        end
    end

    // Stage 6: sort fractions, pick corners, weights, first index product
    logic            gr, gg, gb;
    logic [15:0]     mn, mx, x0, x1, x2, mid;
    logic [LS_W-1:0] cn_a [4];
    logic [LS_W-1:0] cn_b [4];
    logic [LS_W-1:0] cn_c [4];
    logic [WB-1:0]   w6   [4];
    logic [2*LS_W-1:0] s7_ab_reg [4];
    logic [LS_W-1:0]   s7_c_reg  [4];
    logic [WB-1:0]     s7_w_reg  [4];

    always_comb
    begin
        gr  = s6_fr_reg[0] > s6_fr_reg[1];
        gg  = s6_fr_reg[1] > s6_fr_reg[2];
        gb  = s6_fr_reg[2] > s6_fr_reg[0];
        mn  = (s6_fr_reg[0] < s6_fr_reg[1]) ? s6_fr_reg[0] : s6_fr_reg[1];
        mx  = (s6_fr_reg[0] > s6_fr_reg[1]) ? s6_fr_reg[0] : s6_fr_reg[1];
        x2  = (mn < s6_fr_reg[2]) ? mn : s6_fr_reg[2];
        mid = (mn > s6_fr_reg[2]) ? mn : s6_fr_reg[2];
        x0  = (mx > s6_fr_reg[2]) ? mx : s6_fr_reg[2];
        x1  = (mx < mid) ? mx : mid;

        // Corner 0 is the floor, corner 3 the ceiling
        cn_a[0] = s6_prev_reg[0];
        cn_b[0] = s6_prev_reg[1];
        cn_c[0] = s6_prev_reg[2];
        cn_a[1] = (!gb && gr) ? s6_next_reg[0] : s6_prev_reg[0];
        cn_b[1] = (!gr && gg) ? s6_next_reg[1] : s6_prev_reg[1];
        cn_c[1] = (!gg && gb) ? s6_next_reg[2] : s6_prev_reg[2];
        cn_a[2] = (!gr && gb) ? s6_prev_reg[0] : s6_next_reg[0];
        cn_b[2] = (!gg && gr) ? s6_prev_reg[1] : s6_next_reg[1];
        cn_c[2] = (!gb && gg) ? s6_prev_reg[2] : s6_next_reg[2];
        cn_a[3] = s6_next_reg[0];
        cn_b[3] = s6_next_reg[1];
        cn_c[3] = s6_next_reg[2];

        w6[0] = WB'(65536) - WB'(x0);
        w6[1] = WB'(x0) - WB'(x1);
        w6[2] = WB'(x1) - WB'(x2);
        w6[3] = WB'(x2);
    end

    always_ff @(posedge clk)
    begin
        if (f_adv)
        begin
            for (int j = 0; j < 4; j++)
            begin
                s7_ab_reg[j] <= (2 * LS_W)'(cn_a[j]) * (2 * LS_W)'(size)
                              + (2 * LS_W)'(cn_b[j]);
                s7_c_reg[j]  <= cn_c[j];
                s7_w_reg[j]  <= w6[j];
            end
        end
    end

    // Stage 7: finish corner addresses, classify and hand over
    logic [3*LS_W-1:0] s7_full [4];
    logic [LAT_AW-1:0] s7_corner [4];
    logic              is_pix, is_lwr;
    lut3d_pkg::kind_t  kind;

    always_comb
    begin
        for (int j = 0; j < 4; j++)
        begin
            s7_full[j]   = (3 * LS_W)'(s7_ab_reg[j]) * (3 * LS_W)'(size)
                         + (3 * LS_W)'(s7_c_reg[j]);
            s7_corner[j] = s7_full[j][LAT_AW-1:0];
        end
    end

    assign is_pix    = car_reg[7].cmd == lut3d_pkg::CMD_PIXEL;
    assign is_lwr    = car_reg[7].cmd == lut3d_pkg::CMD_LWRITE
                       && 32'(car_reg[7].idx) < 32'(LAT_DEPTH);
    assign push_need = is_pix || is_lwr;
    assign kind      = is_pix ? lut3d_pkg::KIND_PIXEL : lut3d_pkg::KIND_LWRITE;
    assign q_valid   = vld_reg[7] && push_need;
    assign f_adv     = !q_valid || q_ready;

    assign q_data = {kind, car_reg[7].alpha,
                     car_reg[7].smp[0], car_reg[7].smp[1], car_reg[7].smp[2],
                     is_pix ? s7_corner[0] : LAT_AW'(32'(car_reg[7].idx)),
                     s7_corner[1], s7_corner[2], s7_corner[3],
                     s7_w_reg[0], s7_w_reg[1], s7_w_reg[2], s7_w_reg[3]};

endmodule

/* design/lut3d_back.sv */
// Back end: lattice memory, corner reads and tetrahedral blend.
`include "lut3d_tetrahedral_color_map_assert.svh"
module lut3d_back #(
    parameter int MAX_LATTICE = lut3d_pkg::MAX_LATTICE_DEF,
    parameter int SAMPLE_BITS = lut3d_pkg::SAMPLE_BITS_DEF,
    parameter int QW          = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_valid,
    output logic                          q_ready,
    input  logic [QW-1:0]                 q_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [SAMPLE_BITS-1:0] out_red,
    output logic signed [SAMPLE_BITS-1:0] out_green,
    output logic signed [SAMPLE_BITS-1:0] out_blue,
    output logic signed [SAMPLE_BITS-1:0] out_alpha
);
    localparam int S         = SAMPLE_BITS;
    localparam int LAT_DEPTH = MAX_LATTICE * MAX_LATTICE * MAX_LATTICE;
    localparam int LAT_AW    = $clog2(LAT_DEPTH);
    localparam int WB        = lut3d_pkg::WGT_BITS;
    localparam int MW        = S + WB + 1;
    localparam int AW        = S + 20;
    localparam logic signed [AW-1:0] SAT_HI = {{21{1'b0}}, {(S-1){1'b1}}};
    localparam logic signed [AW-1:0] SAT_LO = {{21{1'b1}}, {(S-1){1'b0}}};

    // Unpack the head entry
    lut3d_pkg::kind_t  kind;
    logic [S-1:0]      h_alpha;
    logic [3*S-1:0]    h_data;
    logic [LAT_AW-1:0] h_c [4];
    logic [WB-1:0]     h_w [4];

    assign kind    = lut3d_pkg::kind_t'(q_data[QW-1]);
    assign h_alpha = q_data[QW-2 -: S];
    assign h_data  = q_data[QW-2-S -: 3*S];
    assign h_c[0]  = q_data[4*WB + 4*LAT_AW - 1 -: LAT_AW];
    assign h_c[1]  = q_data[4*WB + 3*LAT_AW - 1 -: LAT_AW];
    assign h_c[2]  = q_data[4*WB + 2*LAT_AW - 1 -: LAT_AW];
    assign h_c[3]  = q_data[4*WB + LAT_AW - 1 -: LAT_AW];
    assign h_w[0]  = q_data[4*WB-1 -: WB];
    assign h_w[1]  = q_data[3*WB-1 -: WB];
    assign h_w[2]  = q_data[2*WB-1 -: WB];
    assign h_w[3]  = q_data[WB-1 -: WB];

    logic              adv;
    logic              head_pix, head_wr;
    logic              phase_reg;
    logic [LAT_AW-1:0] addr_a, addr_b;

    assign adv      = !out_valid || out_ready;
    assign head_pix = q_valid && kind == lut3d_pkg::KIND_PIXEL;
    assign head_wr  = q_valid && kind == lut3d_pkg::KIND_LWRITE;
    assign q_ready  = adv && (head_wr || (head_pix && phase_reg));
    assign addr_a   = phase_reg ? h_c[2] : h_c[0];
    assign addr_b   = phase_reg ? h_c[3] : h_c[1];

    // Lattice memory: one write port, two read ports
    logic [3*S-1:0] lat_mem [LAT_DEPTH];
    logic [3*S-1:0] rd_a_reg, rd_b_reg;

    always_ff @(posedge clk)
    begin
        if (adv && head_wr)
        begin
            lat_mem[h_c[0]] <= h_data;
        end
        if (adv)
        begin
            rd_a_reg <= lat_mem[addr_a];
            rd_b_reg <= lat_mem[addr_b];
        end
    end

    // Issue phase and read-stage control
    logic          r_valid_reg, r_last_reg;
    logic          p_valid_reg;
    logic [WB-1:0] r_w_reg [4];
    logic [S-1:0]  r_alpha_reg, p_alpha_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= 1'b0;
            r_valid_reg <= 1'b0;
            r_last_reg  <= 1'b0;
            p_valid_reg <= 1'b0;
            out_valid   <= 1'b0;
        end
        else if (adv)
        begin
            if (head_pix)
            begin
                phase_reg <= !phase_reg;
            end
            r_valid_reg <= head_pix;
            r_last_reg  <= phase_reg;
            p_valid_reg <= r_valid_reg && r_last_reg;
            out_valid   <= p_valid_reg;
        end
    end

    // Hold the first corner pair, then form all twelve products
    logic [3*S-1:0]       e0_reg, e1_reg;
    logic [3*S-1:0]       ent [4];
    logic signed [MW-1:0] prod_reg [3][4];

    assign ent[0] = e0_reg;
    assign ent[1] = e1_reg;
    assign ent[2] = rd_a_reg;
    assign ent[3] = rd_b_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int j = 0; j < 4; j++)
            begin
                r_w_reg[j] <= h_w[j];
            end
            r_alpha_reg <= h_alpha;
            if (r_valid_reg && !r_last_reg)
            begin
                e0_reg <= rd_a_reg;
                e1_reg <= rd_b_reg;
            end
            for (int c = 0; c < 3; c++)
            begin
                for (int j = 0; j < 4; j++)
                begin
                    prod_reg[c][j] <= MW'($signed({1'b0, r_w_reg[j]}))
                                    * MW'($signed(ent[j][(2-c)*S +: S]));
                end
            end
            p_alpha_reg <= r_alpha_reg;
        end
    end

    // Sum, round half up and saturate
    logic signed [AW-1:0] acc [3];
    logic signed [AW-1:0] rs  [3];
    logic signed [S-1:0]  res [3];

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            acc[c] = AW'(prod_reg[c][0]) + AW'(prod_reg[c][1])
                   + AW'(prod_reg[c][2]) + AW'(prod_reg[c][3]);
            rs[c]  = (acc[c] + AW'(32768)) >>> 16;
            if (rs[c] > SAT_HI)
            begin
                res[c] = SAT_HI[S-1:0];
            end
            else if (rs[c] < SAT_LO)
            begin
                res[c] = SAT_LO[S-1:0];
            end
            else
            begin
                res[c] = rs[c][S-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_red   <= res[0];
            out_green <= res[1];
            out_blue  <= res[2];
            out_alpha <= $signed(p_alpha_reg);
        end
    end

    `LCM_ASSERT(a_phase_holds_pixel, clk, rst_n, phase_reg |-> head_pix)
    `LCM_ASSERT(a_stall_holds_pipe, clk, rst_n, (out_valid && !out_ready) |=> $stable(p_valid_reg))

endmodule

/* design/lut3d_tetrahedral_color_map.sv */
// Top level of the 3D LUT color map with tetrahedral interpolation.
//
//  channel   signals                               direction
//  in        in_valid/in_ready, command..channel   sink
//  out       out_valid/out_ready, out_red..alpha   source
//  cfg       cfg_valid/cfg_ready, cfg_index/data   sink, always ready
//
// In the back end a pixel's four lattice corners are read two per cycle,
// while the output is not stalled, from the two read ports of the lattice
// memory, in two read phases. A pixel passes seven front stages, the queue,
// the two read phases and the blend. Reset is asynchronous and clears only
// control state; memories need no clearing pass. Front and back stall
// independently across a four-entry queue; a full output register holds.
module lut3d_tetrahedral_color_map #(
    parameter int MAX_LATTICE  = lut3d_pkg::MAX_LATTICE_DEF,
    parameter int SHAPER_DEPTH = lut3d_pkg::SHAPER_DEPTH_DEF,
    parameter int SAMPLE_BITS  = lut3d_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [1:0]                    command,
    input  logic signed [SAMPLE_BITS-1:0] red,
    input  logic signed [SAMPLE_BITS-1:0] green,
    input  logic signed [SAMPLE_BITS-1:0] blue,
    input  logic signed [SAMPLE_BITS-1:0] alpha,
    input  logic [15:0]                   entry_index,
    input  logic [1:0]                    shaper_channel,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [SAMPLE_BITS-1:0] out_red,
    output logic signed [SAMPLE_BITS-1:0] out_green,
    output logic signed [SAMPLE_BITS-1:0] out_blue,
    output logic signed [SAMPLE_BITS-1:0] out_alpha,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [2:0]                    cfg_index,
    input  logic [55:0]                   cfg_data
);
    localparam int LAT_DEPTH = MAX_LATTICE * MAX_LATTICE * MAX_LATTICE;
    localparam int LAT_AW    = $clog2(LAT_DEPTH);
    localparam int QW        = 1 + 4 * SAMPLE_BITS + 4 * LAT_AW + 4 * lut3d_pkg::WGT_BITS;

    logic [5:0]       lattice_size_reg;
    logic [10:0]      shaper_size_reg;
    logic [2:0][23:0] scale_reg;
    logic [2:0][55:0] map_reg;

    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lattice_size_reg <= lut3d_pkg::LATTICE_SIZE_RST;
            shaper_size_reg  <= '0;
            scale_reg        <= {3{lut3d_pkg::SCALE_RST}};
            map_reg          <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                lut3d_pkg::CFG_LATTICE_SIZE: lattice_size_reg <= cfg_data[5:0];
                lut3d_pkg::CFG_SHAPER_SIZE:  shaper_size_reg  <= cfg_data[10:0];
                lut3d_pkg::CFG_SCALE_RED:    scale_reg[0]     <= cfg_data[23:0];
                lut3d_pkg::CFG_SCALE_GREEN:  scale_reg[1]     <= cfg_data[23:0];
                lut3d_pkg::CFG_SCALE_BLUE:   scale_reg[2]     <= cfg_data[23:0];
                lut3d_pkg::CFG_MAP_RED:      map_reg[0]       <= cfg_data;
                lut3d_pkg::CFG_MAP_GREEN:    map_reg[1]       <= cfg_data;
                lut3d_pkg::CFG_MAP_BLUE:     map_reg[2]       <= cfg_data;
                default:                     map_reg          <= map_reg;
            endcase
        end
    end

    logic          fq_valid, fq_ready;
    logic [QW-1:0] fq_data;
    logic          qb_valid, qb_ready;
    logic [QW-1:0] qb_data;

    lut3d_front #(
        .MAX_LATTICE  (MAX_LATTICE),
        .SHAPER_DEPTH (SHAPER_DEPTH),
        .SAMPLE_BITS  (SAMPLE_BITS),
        .QW           (QW)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .command        (command),
        .red            (red),
        .green          (green),
        .blue           (blue),
        .alpha          (alpha),
        .entry_index    (entry_index),
        .shaper_channel (shaper_channel),
        .lattice_size   (lattice_size_reg),
        .shaper_size    (shaper_size_reg),
        .scale          (scale_reg),
        .shaper_map     (map_reg),
        .q_valid        (fq_valid),
        .q_ready        (fq_ready),
        .q_data         (fq_data)
    );

    lut3d_queue #(
        .W     (QW),
        .DEPTH (lut3d_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_data  (fq_data),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_data   (qb_data)
    );

    lut3d_back #(
        .MAX_LATTICE (MAX_LATTICE),
        .SAMPLE_BITS (SAMPLE_BITS),
        .QW          (QW)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (qb_valid),
        .q_ready   (qb_ready),
        .q_data    (qb_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_red   (out_red),
        .out_green (out_green),
        .out_blue  (out_blue),
        .out_alpha (out_alpha)
    );

endmodule

/* test/lut3d_tetrahedral_color_map_test.sv */
// Testbench for the 3D LUT color map: predicts each pixel and checks every output transfer.
module lut3d_tetrahedral_color_map_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] CMD_NONE = 2'd3;
    localparam int LAT_DEPTH   = 35937;
    localparam int SHP_DEPTH   = 1024;
    localparam int DRAIN       = 40;
    localparam int CYCLE_LIMIT = 900000;
    localparam int PHASES      = 12;
    localparam int PHASE_ITEMS = 78;

    typedef struct packed {
        logic signed [19:0] r;
        logic signed [19:0] g;
        logic signed [19:0] b;
        logic signed [19:0] a;
    } pixel_out_t;

    // Color map predictor and store of expected pixels
    class color_board;
        int lat [0:LAT_DEPTH-1][0:2];
        int shp [0:3*SHP_DEPTH-1];
        logic [5:0]  lat_size;
        logic [10:0] shp_size;
        logic [23:0] scale [0:2];
        logic [55:0] map [0:2];
        pixel_out_t  pend [$];
        int fails, pixels, writes, regs;

        function new();
            lat_size = lut3d_pkg::LATTICE_SIZE_RST;
            shp_size = '0;
            foreach (scale[k]) scale[k] = lut3d_pkg::SCALE_RST;
            foreach (map[k]) map[k] = '0;
            fails = 0;
            pixels = 0;
            writes = 0;
            regs = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [55:0] data);
            regs++;
            case (idx)
                lut3d_pkg::CFG_LATTICE_SIZE: lat_size = data[5:0];
                lut3d_pkg::CFG_SHAPER_SIZE:  shp_size = data[10:0];
                lut3d_pkg::CFG_SCALE_RED, lut3d_pkg::CFG_SCALE_GREEN,
                lut3d_pkg::CFG_SCALE_BLUE:
                    scale[idx - lut3d_pkg::CFG_SCALE_RED] = data[23:0];
                default: map[idx - lut3d_pkg::CFG_MAP_RED] = data;
            endcase
        endfunction

        function longint round_q16(longint x);
            return (x + 32768) >>> 16;
        endfunction

        // Offset, scale and clamp into the shaper table, then lerp neighbors
        function longint shape_val(int ch, longint v, longint sz);
            longint offset, sc, top, diff, x, prv, nxt, d, p, n;
            offset = longint'($signed(map[ch][55:32]));
            sc = longint'(map[ch][31:0]);
            top = (sz - 1) * 65536;
            diff = v - offset;
            x = (diff <= 0) ? 0 : diff * (sc >> 16) + ((diff * (sc & 65535)) >> 16);
            if (x > top) x = top;
            prv = x >> 16;
            d = x & 65535;
            nxt = (prv + 1 > sz - 1) ? sz - 1 : prv + 1;
            p = shp[ch * SHP_DEPTH + prv];
            n = shp[ch * SHP_DEPTH + nxt];
            return p + round_q16((n - p) * d);
        endfunction

        function pixel_out_t map_pixel(longint sr, longint sg, longint sb,
                                       logic signed [19:0] a);
            longint s [0:2];
            longint prv [0:2], nxt [0:2], fr [0:2], ca [0:2], cb [0:2];
            longint corner [0:3], w [0:3];
            longint sz, lmax, shsz, v, t, pos, mn, mx, x0, x1, x2, mid, acc;
            logic signed [19:0] res [0:2];
            bit gr, gg, gb;
            pixel_out_t o;
            s[0] = sr;
            s[1] = sg;
            s[2] = sb;
            sz = (lat_size < 2) ? 2 : ((lat_size > 33) ? 33 : lat_size);
            lmax = sz - 1;
            shsz = (shp_size > SHP_DEPTH) ? SHP_DEPTH : shp_size;
            // Position each channel on the lattice
            for (int k = 0; k < 3; k++) begin
                v = s[k];
                if (shsz > 0) v = shape_val(k, v, shsz);
                t = v * longint'(scale[k]) * lmax;
                pos = (t <= 0) ? 0 : (t >> 16);
                if (pos > lmax * 65536) pos = lmax * 65536;
                prv[k] = pos >> 16;
                fr[k] = pos & 65535;
                nxt[k] = (prv[k] + 1 > lmax) ? lmax : prv[k] + 1;
            end
            // Pick the tetrahedron from the fraction order
            gr = fr[0] > fr[1];
            gg = fr[1] > fr[2];
            gb = fr[2] > fr[0];
            mn = (fr[0] < fr[1]) ? fr[0] : fr[1];
            mx = (fr[0] > fr[1]) ? fr[0] : fr[1];
            x2 = (mn < fr[2]) ? mn : fr[2];
            mid = (mn > fr[2]) ? mn : fr[2];
            x0 = (mx > fr[2]) ? mx : fr[2];
            x1 = (mx < mid) ? mx : mid;
            ca[0] = (!gb && gr) ? nxt[0] : prv[0];
            ca[1] = (!gr && gg) ? nxt[1] : prv[1];
            ca[2] = (!gg && gb) ? nxt[2] : prv[2];
            cb[0] = (!gr && gb) ? prv[0] : nxt[0];
            cb[1] = (!gg && gr) ? prv[1] : nxt[1];
            cb[2] = (!gb && gg) ? prv[2] : nxt[2];
            corner[0] = (prv[0] * sz + prv[1]) * sz + prv[2];
            corner[1] = (ca[0] * sz + ca[1]) * sz + ca[2];
            corner[2] = (cb[0] * sz + cb[1]) * sz + cb[2];
            corner[3] = (nxt[0] * sz + nxt[1]) * sz + nxt[2];
            w[0] = 65536 - x0;
            w[1] = x0 - x1;
            w[2] = x1 - x2;
            w[3] = x2;
            // Blend, round and saturate
            for (int c = 0; c < 3; c++) begin
                acc = 0;
                for (int j = 0; j < 4; j++) acc += w[j] * longint'(lat[corner[j]][c]);
                acc = round_q16(acc);
                if (acc > 524287) acc = 524287;
                if (acc < -524288) acc = -524288;
                res[c] = acc[19:0];
            end
            o.r = res[0];
            o.g = res[1];
            o.b = res[2];
            o.a = a;
            return o;
        endfunction

        function void note_input(logic [1:0] cmd, logic signed [19:0] r, g, b, a,
                                 logic [15:0] idx, logic [1:0] ch);
            case (cmd)
                lut3d_pkg::CMD_LWRITE: begin
                    writes++;
                    if (idx < LAT_DEPTH) begin
                        lat[idx][0] = r;
                        lat[idx][1] = g;
                        lat[idx][2] = b;
                    end
                end
                lut3d_pkg::CMD_SWRITE: begin
                    writes++;
                    if (ch < 3 && idx < SHP_DEPTH) shp[ch * SHP_DEPTH + idx] = r;
                end
                lut3d_pkg::CMD_PIXEL: begin
                    pixels++;
                    pend.push_back(map_pixel(r, g, b, a));
                end
                default: ;
            endcase
        endfunction

        function void cmp_field(string nm, logic signed [19:0] e, logic signed [19:0] g);
            if (e !== g) begin
                fails++;
                $display("%0t: %s mismatch, expected %0d actual %0d", $time, nm, e, g);
            end
        endfunction

        function void check_result(pixel_out_t got);
            pixel_out_t e;
            if (pend.size() == 0) begin
                fails++;
                $display("%0t: unexpected pixel, expected none actual %0d %0d %0d %0d",
                         $time, got.r, got.g, got.b, got.a);
                return;
            end
            e = pend.pop_front();
            cmp_field("out_red", e.r, got.r);
            cmp_field("out_green", e.g, got.g);
            cmp_field("out_blue", e.b, got.b);
            cmp_field("out_alpha", e.a, got.a);
        endfunction

        function int pending();
            return pend.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic [1:0] command;
    logic signed [19:0] red, green, blue, alpha;
    logic [15:0] entry_index;
    logic [1:0] shaper_channel;
    logic out_valid;
    logic out_ready;
    logic signed [19:0] out_red, out_green, out_blue, out_alpha;
    logic cfg_valid;
    logic cfg_ready;
    logic [2:0] cfg_index;
    logic [55:0] cfg_data;

    color_board board;
    int in_idle;
    int out_idle;
    int hold_cycles;
    int cycles;

    lut3d_tetrahedral_color_map u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .command(command), .red(red), .green(green), .blue(blue), .alpha(alpha),
        .entry_index(entry_index), .shaper_channel(shaper_channel),
        .out_valid(out_valid), .out_ready(out_ready),
        .out_red(out_red), .out_green(out_green), .out_blue(out_blue),
        .out_alpha(out_alpha),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Free-running clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Bound the run
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Accept output transfers and drive random backpressure
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            board.check_result('{out_red, out_green, out_blue, out_alpha});
        if (hold_cycles > 0) begin
            hold_cycles--;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= out_idle);
        end
    end

    function automatic logic signed [19:0] rnd20();
        return 20'($urandom);
    endfunction

    // Sample that lands next to the low or high face of a 33-point lattice at unit scale
    function automatic logic signed [19:0] face_sample();
        if ($urandom_range(1))
            return $urandom_range(63488, 524287);
        return $signed($urandom_range(0, 526335)) - 524288;
    endfunction

    function automatic int face_coord();
        int c;
        c = $urandom_range(3);
        return (c < 2) ? c : c + 29;
    endfunction

    task automatic send_item(logic [1:0] cmd, logic signed [19:0] r, g, b, a,
                             logic [15:0] idx, logic [1:0] ch);
        while ($urandom_range(99) < in_idle) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        command <= cmd;
        red <= r;
        green <= g;
        blue <= b;
        alpha <= a;
        entry_index <= idx;
        shaper_channel <= ch;
        do @(posedge clk); while (!in_ready);
        board.note_input(cmd, r, g, b, a, idx, ch);
    endtask

    task automatic send_pixel(logic signed [19:0] r, g, b, a);
        send_item(lut3d_pkg::CMD_PIXEL, r, g, b, a, $urandom, $urandom);
    endtask

    // Drop valid, wait for every pixel to drain, then let the pipeline settle
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (board.pending() != 0) @(posedge clk);
        repeat (DRAIN) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [55:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        board.set_reg(idx, data);
        @(posedge clk);
    endtask

    task automatic directed_items();
        logic signed [19:0] mx, mn;
        mx = 20'sh7FFFF;
        mn = 20'sh80000;
        write_reg(lut3d_pkg::CFG_LATTICE_SIZE, 2);
        for (int k = 0; k < 8; k++) begin
            if (k == 0) send_item(lut3d_pkg::CMD_LWRITE, mn, mn, mn, 0, k, 0);
            else if (k == 7) send_item(lut3d_pkg::CMD_LWRITE, mx, mx, mx, 0, k, 0);
            else send_item(lut3d_pkg::CMD_LWRITE, rnd20(), rnd20(), rnd20(), 0, k, 0);
        end
        // Field extremes
        send_pixel(0, 0, 0, mn);
        send_pixel(mx, mx, mx, mx);
        send_pixel(mn, mn, mn, 0);
        // All fractions tied, then pairs tied
        send_pixel(32768, 32768, 32768, 1);
        send_pixel(40000, 40000, 20000, 2);
        send_pixel(20000, 40000, 40000, 3);
        send_pixel(40000, 20000, 40000, 4);
        // Every ordering of three distinct fractions
        send_pixel(50000, 30000, 10000, 5);
        send_pixel(50000, 10000, 30000, 6);
        send_pixel(30000, 50000, 10000, 7);
        send_pixel(10000, 50000, 30000, 8);
        send_pixel(30000, 10000, 50000, 9);
        send_pixel(10000, 30000, 50000, 10);
        // Ignored writes, a write to the last lattice cell and the unused command
        send_item(lut3d_pkg::CMD_LWRITE, mx, mx, mx, 0, 16'hFFFF, 0);
        send_item(lut3d_pkg::CMD_LWRITE, rnd20(), rnd20(), rnd20(), 0, LAT_DEPTH - 1, 0);
        send_item(lut3d_pkg::CMD_SWRITE, mx, 0, 0, 0, 0, 2'd3);
        send_item(lut3d_pkg::CMD_SWRITE, mx, 0, 0, 0, SHP_DEPTH, 0);
        send_item(CMD_NONE, rnd20(), rnd20(), rnd20(), rnd20(), $urandom, $urandom);
        send_pixel(65535, 1, 65536, rnd20());
    endtask

    task automatic run_phase(int p);
        int sizes [0:PHASES-1] = '{2, 3, 4, 5, 0, 33, 1, 5, 40, 63, 4, 3};
        int n_shp [0:3] = '{1, 2, 8, 16};
        int n_big [0:2] = '{1024, 2047, 1500};
        int eff, cells, nsh, sel;
        logic [23:0] sc;
        logic [55:0] mp;
        bit face;
        eff = (sizes[p] < 2) ? 2 : ((sizes[p] > 33) ? 33 : sizes[p]);
        face = (eff == 33);
        cells = eff * eff * eff;
        wait_idle();
        write_reg(lut3d_pkg::CFG_LATTICE_SIZE, sizes[p]);
        // Scales: unit for the sparse big lattice, else extremes or random
        for (int k = 0; k < 3; k++) begin
            if (face) sc = lut3d_pkg::SCALE_RST;
            else if (p == 2) sc = '0;
            else if (p == 3) sc = 24'hFFFFFF;
            else if ($urandom_range(4) == 0) sc = $urandom;
            else sc = $urandom_range(0, 200000);
            write_reg(lut3d_pkg::CFG_SCALE_RED + k, sc);
        end
        // Shaper: off, a small full table, or a large table held at its first entry
        nsh = 0;
        if (!face && p % 3 == 1) nsh = n_shp[(p / 3) % 4];
        if (!face && p % 3 == 2) nsh = n_big[(p / 3) % 3];
        write_reg(lut3d_pkg::CFG_SHAPER_SIZE, nsh);
        for (int k = 0; k < 3; k++) begin
            mp[55:32] = $urandom;
            mp[31:0] = $urandom_range(1) ? $urandom : $urandom_range(0, 1 << 21);
            if (nsh > SHP_DEPTH / 2) mp[31:0] = '0;
            write_reg(lut3d_pkg::CFG_MAP_RED + k, mp);
        end
        if (nsh > 0) begin
            for (int k = 0; k < 3; k++)
                for (int i = 0; i < ((nsh > 16) ? 2 : nsh); i++)
                    send_item(lut3d_pkg::CMD_SWRITE, rnd20(), rnd20(), 0, 0, i, k);
        end
        // Fill the lattice cells that pixels can reach
        if (face) begin
            for (int i = 0; i < 64; i++)
                send_item(lut3d_pkg::CMD_LWRITE, rnd20(), rnd20(), rnd20(), 0,
                          ((((i >> 4) & 3) < 2 ? (i >> 4) & 3 : ((i >> 4) & 3) + 29) * 33
                           + (((i >> 2) & 3) < 2 ? (i >> 2) & 3 : ((i >> 2) & 3) + 29)) * 33
                          + ((i & 3) < 2 ? i & 3 : (i & 3) + 29), 0);
        end else begin
            for (int i = 0; i < cells; i++)
                send_item(lut3d_pkg::CMD_LWRITE, rnd20(), rnd20(), rnd20(), 0, i, 0);
        end
        // Let the output stall long enough to back up the input
        if (p == 1) hold_cycles = 400;
        for (int i = 0; i < PHASE_ITEMS; i++) begin
            sel = $urandom_range(99);
            if (sel < 3)
                send_item(lut3d_pkg::CMD_LWRITE, rnd20(), rnd20(), rnd20(), rnd20(),
                          $urandom_range(LAT_DEPTH, 65535), $urandom);
            else if (sel < 5)
                send_item(lut3d_pkg::CMD_SWRITE, rnd20(), rnd20(), rnd20(), rnd20(),
                          $urandom_range(1) ? $urandom_range(SHP_DEPTH, 65535) : $urandom,
                          $urandom_range(1) ? 2'd3 : $urandom);
            else if (sel < 7)
                send_item(CMD_NONE, rnd20(), rnd20(), rnd20(), rnd20(), $urandom, $urandom);
            else if (sel < 14)
                send_item(lut3d_pkg::CMD_LWRITE, rnd20(), rnd20(), rnd20(), rnd20(),
                          face ? (face_coord() * 33 + face_coord()) * 33 + face_coord()
                               : $urandom_range(0, cells - 1), $urandom);
            else if (face)
                send_pixel(face_sample(), face_sample(), face_sample(), rnd20());
            else
                send_pixel(rnd20(), rnd20(), rnd20(), rnd20());
        end
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        command = lut3d_pkg::CMD_PIXEL;
        red = '0;
        green = '0;
        blue = '0;
        alpha = '0;
        entry_index = '0;
        shaper_channel = '0;
        out_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = lut3d_pkg::CFG_LATTICE_SIZE;
        cfg_data = '0;
        hold_cycles = 0;
        cycles = 0;
        in_idle = 26;
        out_idle = 46;
        board = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        directed_items();
        for (int p = 0; p < PHASES; p++) begin
            // Receiver-heavy idling, then sender-heavy, then none
            in_idle = (p < 4) ? 26 : ((p < 8) ? 46 : 0);
            out_idle = (p < 4) ? 46 : ((p < 8) ? 26 : 0);
            run_phase(p);
        end
        wait_idle();
        $display("Mapped %0d pixels across %0d table writes and %0d register writes,",
                 board.pixels, board.writes, board.regs);
        $display("covering lattice sizes 0 to 63, shaper on and off, and stalls on both sides.");
        if (board.fails == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
